[sv/b2da_pkg.sv]
// Shared constants and power-of-ten tables for the binary to decimal ASCII converter.
`default_nettype none

package b2da_pkg;

    // Width of the input field and the longest run it can produce
    localparam int FIELD_BITS = 32;
    localparam int MAX_DIGITS = 10;

    // Compare width: holds 9 * 10^9
    localparam int PW = 34;

    // ASCII code of '0' in the 6-bit result field
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    typedef logic [PW-1:0]                 pw_t;
    typedef pw_t  [MAX_DIGITS-1:0]         mult_row_t;
    typedef mult_row_t [MAX_DIGITS-1:0]    mult_tab_t;

    // tab[k][d] = d * 10^k, evaluated at elaboration only
    function automatic mult_tab_t build_mult_tab();
        mult_tab_t tab;
        pw_t       p;
        p = pw_t'(1);
        for (int k = 0; k < MAX_DIGITS; k++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                tab[k][d] = pw_t'(d) * p;
            end
            p = p * pw_t'(10);
        end
        return tab;
    endfunction

    localparam mult_tab_t MULT_TAB = build_mult_tab();

endpackage

`default_nettype wire

[sv/b2da_fifo.sv]
// Small flop-based queue between the front and back ends.
`default_nettype none

module b2da_fifo #(
    parameter int W     = 36,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic              not_empty,
    output logic [W-1:0]      head_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[sv/b2da_front.sv]
// Front end: masks the incoming value and finds the index of its leading digit.
`default_nettype none

module b2da_front
    import b2da_pkg::*;
#(
    parameter int VAL_W = 32,
    parameter int KW    = 4,
    parameter int NDIG  = 10
) (
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [FIELD_BITS-1:0] s_tdata,   // [31:0] value
    input  wire logic                  q_full,
    output logic                       q_push,
    output logic [KW+VAL_W-1:0]        q_data     // {top digit index, value}
);

    logic [VAL_W-1:0] val;
    logic [KW-1:0]    top_k;

    assign val = s_tdata[VAL_W-1:0];

    // Index of the leading digit = number of powers of ten from 10 upward not above the value
    always_comb
    begin
        top_k = '0;
        for (int j = 1; j < NDIG; j++)
        begin
            top_k = top_k + KW'(pw_t'(val) >= MULT_TAB[j][1]);
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;
    assign q_data   = {top_k, val};

endmodule

`default_nettype wire

[sv/b2da_back.sv]
// Back end: emits one decimal digit per cycle while the output is not stalled, most significant first.
`default_nettype none

module b2da_back
    import b2da_pkg::*;
#(
    parameter int VAL_W = 32,
    parameter int KW    = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_not_empty,
    input  wire logic [KW+VAL_W-1:0] q_data,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [5:0]             char_code,
    output logic                   m_tlast
);

    logic             busy_reg, busy_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             out_valid_reg;
    logic [5:0]       out_char_reg;
    logic             out_last_reg;

    logic [VAL_W-1:0] src_rem;
    logic [KW-1:0]    src_k;
    logic             step;
    mult_row_t        row;
    logic [3:0]       digit;

    // Work comes from the engine while busy, otherwise straight from the queue head
    assign src_rem = busy_reg ? rem_reg : q_data[VAL_W-1:0];
    assign src_k   = busy_reg ? k_reg   : q_data[KW+VAL_W-1:VAL_W];
    assign step    = (busy_reg || q_not_empty) && (!out_valid_reg || m_tready);
    assign q_pop   = step && !busy_reg;

    // One digit: parallel compares against d * 10^k, then subtract the match
    always_comb
    begin
        row   = MULT_TAB[src_k];
        digit = '0;
        for (int d = 1; d < MAX_DIGITS; d++)
        begin
            digit = digit + 4'(pw_t'(src_rem) >= row[d]);
        end
        rem_next  = VAL_W'(pw_t'(src_rem) - row[digit]);
        k_next    = src_k - 1'b1;
        busy_next = busy_reg;
        if (step)
        begin
            busy_next = (src_k != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rem_reg      <= rem_next;
            k_reg        <= k_next;
            out_char_reg <= ASCII_ZERO + 6'(digit);
            out_last_reg <= (src_k == '0);
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign char_code = out_char_reg;
    assign m_tlast   = out_last_reg;

endmodule

`default_nettype wire

[sv/binary_to_decimal_ascii.sv]
// Path: an accepted value is written into the queue; the compare and subtract
// unit then forms its digits, most significant first (10 for the largest
// values), and registers them for output at one character per cycle while the
// output is not stalled. A two-entry queue lets input run ahead of output.
// Reset: asynchronous, active low; clears the queue, the engine and output valid.
// Top level of the unsigned binary to decimal ASCII converter.
`default_nettype none

module binary_to_decimal_ascii
    import b2da_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [FIELD_BITS-1:0] s_tdata,   // [31:0] value
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [5:0] char_code, [7:6] zero
    output logic                       m_tlast    // is_last
);

    localparam int VAL_W = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int NDIG  = ((VAL_W * 1233) >> 12) + 1;
    localparam int KW    = $clog2(NDIG);
    localparam int QW    = KW + VAL_W;

    logic          q_full;
    logic          q_push;
    logic [QW-1:0] q_wdata;
    logic          q_pop;
    logic          q_not_empty;
    logic [QW-1:0] q_head;
    logic [5:0]    char_code;

    b2da_front #(
        .VAL_W (VAL_W),
        .KW    (KW),
        .NDIG  (NDIG)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    b2da_fifo #(
        .W     (QW),
        .DEPTH (2)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (q_head)
    );

    b2da_back #(
        .VAL_W (VAL_W),
        .KW    (KW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .char_code   (char_code),
        .m_tlast     (m_tlast)
    );

    assign m_tdata = {2'b00, char_code};

endmodule

`default_nettype wire

[sv/b2da_checker.sv]
// Port-level checker for the binary to decimal ASCII converter, bound to the top.
`default_nettype none

module b2da_checker
    import b2da_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    logic [7:0] pending_reg;
    logic [3:0] run_len_reg;
    logic       in_acc;
    logic       out_end;

    assign in_acc  = s_tvalid && s_tready;
    assign out_end = m_tvalid && m_tready && m_tlast;

    // Values accepted whose run has not ended, and digits sent in the current run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            run_len_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 8'(in_acc) - 8'(out_end);
            if (out_end)
            begin
                run_len_reg <= '0;
            end
            else if (m_tvalid && m_tready)
            begin
                run_len_reg <= run_len_reg + 1'b1;
            end
        end
    end

    // Stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Only digit codes appear
    a_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:6] == 2'b00 && m_tdata[5:0] >= ASCII_ZERO
            && m_tdata[5:0] <= ASCII_ZERO + 6'd9)
        else $error("character is not a decimal digit");

    // No leading zero: a '0' opening a run is the whole run
    a_no_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && run_len_reg == 4'd0 && m_tdata[5:0] == ASCII_ZERO |-> m_tlast)
        else $error("leading zero emitted");

    // No output without an accepted value, and no run past ten characters
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 8'd0)
        else $error("output with no value outstanding");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && run_len_reg == 4'(MAX_DIGITS - 1) |-> m_tlast)
        else $error("run longer than ten characters");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

`default_nettype wire
